@@ design/pcx_pkg.sv @@
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types, constants and helpers for the permutation segment crossover.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam int MAX_CITIES = 32;
    localparam int LEN_CAP    = (MAX_CITIES < 32) ? MAX_CITIES : 32;
    localparam int POS_W      = $clog2(LEN_CAP);
    localparam int CNT_W      = POS_W + 1;
    localparam int CITY_W     = 5;
    localparam int TL_W       = 6;
    localparam int MIN_LEN    = 2;

    localparam logic [TL_W-1:0] TOUR_LENGTH_RESET = TL_W'(32);

    typedef struct packed {
        logic [CITY_W-1:0] parent_one_city;
        logic [CITY_W-1:0] parent_two_city;
        logic [CITY_W-1:0] segment_end_a;
        logic [CITY_W-1:0] segment_end_b;
    } in_item_t;

    typedef struct packed {
        logic [CITY_W-1:0] child_one_city;
        logic [CITY_W-1:0] child_two_city;
        logic              last_position;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MARK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic mark_step;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic mark_last;
        logic emit_last;
        logic out_valid;
    } sts_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] idx;
    } pick_t;

    // lowest set bit wins
    function automatic pick_t first_free(input logic [LEN_CAP-1:0] mask);
        pick_t r;
        r.found = |mask;
        r.idx   = '0;
        for (int k = LEN_CAP - 1; k >= 0; k--) begin
            if (mask[k]) begin
                r.idx = POS_W'(k);
            end
        end
        return r;
    endfunction

    // tour length saturated into [MIN_LEN, LEN_CAP]
    function automatic logic [CNT_W-1:0] eff_length(input logic [TL_W-1:0] tl);
        logic [CNT_W-1:0] r;
        if (tl > TL_W'(LEN_CAP)) begin
            r = CNT_W'(LEN_CAP);
        end else if (tl < TL_W'(MIN_LEN)) begin
            r = CNT_W'(MIN_LEN);
        end else begin
            r = CNT_W'(tl);
        end
        return r;
    endfunction

endpackage

@@ design/pcx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcx_ctrl
// Sequencer: load parents, mark segment cities, emit the two children.
// ----------------------------------------------------------------------------
module pcx_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          m_ready,
    input  pcx_pkg::sts_t sts,
    output pcx_pkg::cmd_t cmd
);
    import pcx_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (cmd.load_wr && sts.load_last) begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                if (sts.mark_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.emit_step && sts.emit_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load_wr   = 1'b0;
        cmd.mark_step = 1'b0;
        cmd.emit_step = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_wr = s_valid;
            end
            ST_MARK: begin
                cmd.mark_step = 1'b1;
            end
            ST_EMIT: begin
                // output register free or being drained this cycle
                cmd.emit_step = !sts.out_valid || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/pcx_datapath.sv @@
// ----------------------------------------------------------------------------
// pcx_datapath
// Parent stores, skip marks, source scan pointers and the result register.
// ----------------------------------------------------------------------------
module pcx_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pcx_pkg::TL_W-1:0]    cfg_wr_data,
    input  pcx_pkg::in_item_t           s_data,
    input  pcx_pkg::cmd_t               cmd,
    output pcx_pkg::sts_t               sts,
    input  logic                        m_ready,
    output logic                        m_valid,
    output pcx_pkg::out_item_t          m_data
);
    import pcx_pkg::*;

    logic [TL_W-1:0]    tour_length_reg;
    logic [CNT_W-1:0]   load_count_reg;
    logic [CNT_W-1:0]   load_count_next;
    logic [CITY_W-1:0]  p1_reg [LEN_CAP];
    logic [CITY_W-1:0]  p2_reg [LEN_CAP];
    logic [POS_W-1:0]   seg_lo_reg, seg_lo_next;
    logic [POS_W-1:0]   seg_hi_reg, seg_hi_next;
    logic [POS_W-1:0]   mark_idx_reg, mark_idx_next;
    logic [LEN_CAP-1:0] skip1_reg, skip1_next;
    logic [LEN_CAP-1:0] skip2_reg, skip2_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   src1_reg, src1_next;
    logic [CNT_W-1:0]   src2_reg, src2_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic [CNT_W-1:0]   len;
    logic [POS_W-1:0]   len_m1;
    logic [POS_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   wr_idx_inc;
    logic [POS_W-1:0]   end_a, end_b;
    logic [LEN_CAP-1:0] free1, free2;
    pick_t              pick1, pick2;
    logic               in_seg;
    logic [POS_W-1:0]   rd1_addr, rd2_addr;
    logic [CITY_W-1:0]  rd1, rd2;

    assign len    = eff_length(tour_length_reg);
    assign len_m1 = POS_W'(len - CNT_W'(1));

    // restart the load if the length shrank below the fill point
    assign wr_idx     = (load_count_reg >= len) ? '0 : load_count_reg[POS_W-1:0];
    assign wr_idx_inc = CNT_W'(wr_idx) + CNT_W'(1);

    assign end_a = ({1'b0, s_data.segment_end_a} > TL_W'(len_m1))
                 ? len_m1 : POS_W'(s_data.segment_end_a);
    assign end_b = ({1'b0, s_data.segment_end_b} > TL_W'(len_m1))
                 ? len_m1 : POS_W'(s_data.segment_end_b);

    // unmarked source positions at or above the scan pointer and inside the tour
    always_comb begin
        for (int k = 0; k < LEN_CAP; k++) begin
            free1[k] = !skip1_reg[k] && (CNT_W'(k) >= src1_reg) && (CNT_W'(k) < len);
            free2[k] = !skip2_reg[k] && (CNT_W'(k) >= src2_reg) && (CNT_W'(k) < len);
        end
    end

    assign pick1  = first_free(free1);
    assign pick2  = first_free(free2);
    assign in_seg = (pos_reg >= seg_lo_reg) && (pos_reg <= seg_hi_reg);

    // one read address per store
    assign rd1_addr = cmd.mark_step ? mark_idx_reg : (in_seg ? pos_reg : pick1.idx);
    assign rd2_addr = cmd.mark_step ? mark_idx_reg : (in_seg ? pos_reg : pick2.idx);
    assign rd1      = p1_reg[rd1_addr];
    assign rd2      = p2_reg[rd2_addr];

    assign sts.load_last = (wr_idx_inc == len);
    assign sts.mark_last = (mark_idx_reg == seg_hi_reg);
    assign sts.emit_last = (pos_reg == len_m1);
    assign sts.out_valid = out_valid_reg;

    always_comb begin
        load_count_next = load_count_reg;
        seg_lo_next     = seg_lo_reg;
        seg_hi_next     = seg_hi_reg;
        mark_idx_next   = mark_idx_reg;
        skip1_next      = skip1_reg;
        skip2_next      = skip2_reg;
        pos_next        = pos_reg;
        src1_next       = src1_reg;
        src2_next       = src2_reg;
        out_data_next   = out_data_reg;

        if (cmd.load_wr) begin
            load_count_next = sts.load_last ? '0 : wr_idx_inc;
            if (sts.load_last) begin
                seg_lo_next   = (end_a < end_b) ? end_a : end_b;
                seg_hi_next   = (end_a < end_b) ? end_b : end_a;
                mark_idx_next = (end_a < end_b) ? end_a : end_b;
                skip1_next    = '0;
                skip2_next    = '0;
            end
        end

        if (cmd.mark_step) begin
            for (int j = 0; j < LEN_CAP; j++) begin
                skip1_next[j] = skip1_reg[j] || (p1_reg[j] == rd2);
                skip2_next[j] = skip2_reg[j] || (p2_reg[j] == rd1);
            end
            mark_idx_next = mark_idx_reg + POS_W'(1);
            if (sts.mark_last) begin
                pos_next  = '0;
                src1_next = '0;
                src2_next = '0;
            end
        end

        if (cmd.emit_step) begin
            out_data_next.last_position = sts.emit_last;
            if (in_seg) begin
                out_data_next.child_one_city = rd2;
                out_data_next.child_two_city = rd1;
            end else begin
                // exhausted source fills with city 0
                out_data_next.child_one_city = pick1.found ? rd1 : '0;
                out_data_next.child_two_city = pick2.found ? rd2 : '0;
                if (pick1.found) begin
                    src1_next = CNT_W'(pick1.idx) + CNT_W'(1);
                end
                if (pick2.found) begin
                    src2_next = CNT_W'(pick2.idx) + CNT_W'(1);
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb begin
        if (cmd.emit_step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tour_length_reg <= TOUR_LENGTH_RESET;
            load_count_reg  <= '0;
            skip1_reg       <= '0;
            skip2_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tour_length_reg <= cfg_wr_data;
            end
            load_count_reg <= load_count_next;
            skip1_reg      <= skip1_next;
            skip2_reg      <= skip2_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seg_lo_reg   <= seg_lo_next;
        seg_hi_reg   <= seg_hi_next;
        mark_idx_reg <= mark_idx_next;
        pos_reg      <= pos_next;
        src1_reg     <= src1_next;
        src2_reg     <= src2_next;
        out_data_reg <= out_data_next;
        if (cmd.load_wr) begin
            p1_reg[wr_idx] <= s_data.parent_one_city;
            p2_reg[wr_idx] <= s_data.parent_two_city;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ design/permutation_segment_crossover.sv @@
// ----------------------------------------------------------------------------
// permutation_segment_crossover
// Segment crossover of two tour permutations, one position pair per transaction.
// ----------------------------------------------------------------------------
// Timing: each input transaction loads one position of both parents. The
// transaction that completes the tour starts a marking pass over positions
// lo to hi, one segment position per cycle through one compare row per
// parent store against all stored cities, then emission of one result per
// cycle (stalled only by m_ready). s_ready is low during marking and
// emission; the last result may still sit in the output register while the
// next load begins. No clearing pass is needed after reset.
module permutation_segment_crossover (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [pcx_pkg::TL_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  pcx_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output pcx_pkg::out_item_t       m_data
);
    import pcx_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pcx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcx_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_wr && cmd.mark_step) && !(cmd.load_wr && cmd.emit_step))
        else $error("load overlaps mark or emit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_step |-> (!m_valid || m_ready))
        else $error("result register overwritten while held");

    a_load_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_wr && sts.load_last) |=> !s_ready)
        else $error("input still open after tour completed");

    a_emit_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_step && sts.emit_last) |=> (s_ready && m_valid && m_data.last_position))
        else $error("final result or reopen missing");

endmodule

@@ dv/permutation_segment_crossover_tb.sv @@
// ----------------------------------------------------------------------------
// permutation_segment_crossover_tb
// Loads parent tours of random and extreme lengths into the crossover block,
// predicts both children per position and checks every result transaction in
// order, under three idle profiles and one long output stall.
// ----------------------------------------------------------------------------
module permutation_segment_crossover_tb;
    import pcx_pkg::*;

    localparam int CITY_COUNT    = 1 << CITY_W;
    localparam int SETTLE_CYCLES = 3 * LEN_CAP + 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;

    // Tracks both parent stores and queues the children each completed tour yields.
    class crossover_board;
        logic [TL_W-1:0]   tour_length;
        logic [CITY_W-1:0] tour_one [LEN_CAP];
        logic [CITY_W-1:0] tour_two [LEN_CAP];
        int unsigned       load_pos;
        out_item_t         child_pairs_q [$];
        int unsigned       errors;
        int unsigned       inputs_seen;
        int unsigned       tours_done;
        int unsigned       results_seen;

        function new();
            tour_length  = TOUR_LENGTH_RESET;
            load_pos     = 0;
            errors       = 0;
            inputs_seen  = 0;
            tours_done   = 0;
            results_seen = 0;
        endfunction

        function void set_length(logic [TL_W-1:0] v);
            tour_length = v;
        endfunction

        function int unsigned active_length();
            if (tour_length > LEN_CAP) return LEN_CAP;
            if (tour_length < MIN_LEN) return MIN_LEN;
            return tour_length;
        endfunction

        function int unsigned pending();
            return child_pairs_q.size();
        endfunction

        function void load_position(in_item_t it);
            int unsigned        len, end_a, end_b, lo, hi, src_one, src_two;
            logic [LEN_CAP-1:0] skip_one, skip_two;
            out_item_t          r;
            inputs_seen++;
            len = active_length();
            // length shrunk under a partial load: start over
            if (load_pos >= len) load_pos = 0;
            tour_one[load_pos] = it.parent_one_city;
            tour_two[load_pos] = it.parent_two_city;
            load_pos++;
            if (load_pos < len) return;
            load_pos = 0;
            tours_done++;

            end_a = (it.segment_end_a > len - 1) ? len - 1 : it.segment_end_a;
            end_b = (it.segment_end_b > len - 1) ? len - 1 : it.segment_end_b;
            lo    = (end_a < end_b) ? end_a : end_b;
            hi    = (end_a < end_b) ? end_b : end_a;

            skip_one = '0;
            skip_two = '0;
            for (int unsigned i = lo; i <= hi; i++) begin
                for (int unsigned j = 0; j < len; j++) begin
                    if (tour_one[j] == tour_two[i]) skip_one[j] = 1'b1;
                    if (tour_two[j] == tour_one[i]) skip_two[j] = 1'b1;
                end
            end

            src_one = 0;
            src_two = 0;
            for (int unsigned i = 0; i < len; i++) begin
                r = '0;
                if (i >= lo && i <= hi) begin
                    r.child_one_city = tour_two[i];
                    r.child_two_city = tour_one[i];
                end else begin
                    while (src_one < len && skip_one[src_one]) src_one++;
                    while (src_two < len && skip_two[src_two]) src_two++;
                    // source used up: position stays city 0
                    if (src_one < len) begin
                        r.child_one_city = tour_one[src_one];
                        src_one++;
                    end
                    if (src_two < len) begin
                        r.child_two_city = tour_two[src_two];
                        src_two++;
                    end
                end
                r.last_position = (i == len - 1);
                child_pairs_q = {child_pairs_q, r};
            end
        endfunction

        function void check_child_pair(out_item_t got);
            out_item_t want;
            results_seen++;
            if (child_pairs_q.size() == 0) begin
                $display("%0t: unexpected result c1=%0d c2=%0d last=%0b", $time,
                         got.child_one_city, got.child_two_city, got.last_position);
                errors++;
                return;
            end
            want = child_pairs_q.pop_front();
            if (got.child_one_city !== want.child_one_city) begin
                $display("%0t: child_one_city expected %0d got %0d", $time,
                         want.child_one_city, got.child_one_city);
                errors++;
            end
            if (got.child_two_city !== want.child_two_city) begin
                $display("%0t: child_two_city expected %0d got %0d", $time,
                         want.child_two_city, got.child_two_city);
                errors++;
            end
            if (got.last_position !== want.last_position) begin
                $display("%0t: last_position expected %0b got %0b", $time,
                         want.last_position, got.last_position);
                errors++;
            end
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            cfg_wr_en;
    logic [TL_W-1:0] cfg_wr_data;
    logic            s_valid;
    logic            s_ready;
    in_item_t        s_data;
    logic            m_valid;
    logic            m_ready;
    out_item_t       m_data;

    crossover_board board = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned cycle_count;

    permutation_segment_crossover dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("FAIL permutation_segment_crossover");
            $finish;
        end
    end

    // receiver: long hold-off takes priority over random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_child_pair(m_data);
    end

    function automatic void shuffle_cities(ref logic [CITY_W-1:0] arr[CITY_COUNT],
                                           input int unsigned n);
        int unsigned       j;
        logic [CITY_W-1:0] t;
        for (int i = int'(n) - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            t      = arr[i];
            arr[i] = arr[j];
            arr[j] = t;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        board.load_position(it);
        @(negedge aclk);
    endtask

    task automatic drive_fields(input logic [CITY_W-1:0] c1, input logic [CITY_W-1:0] c2,
                                input logic [CITY_W-1:0] ea, input logic [CITY_W-1:0] eb);
        in_item_t it;
        it.parent_one_city = c1;
        it.parent_two_city = c2;
        it.segment_end_a   = ea;
        it.segment_end_b   = eb;
        drive_item(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_tour_length(input logic [TL_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_length(v);
    endtask

    // mostly two orderings of one city set; some tours are noise or near-permutations
    task automatic load_tour(input int unsigned len, input int unsigned count);
        logic [CITY_W-1:0] tour_a [CITY_COUNT];
        logic [CITY_W-1:0] tour_b [CITY_COUNT];
        in_item_t          it;
        int unsigned       kind;
        for (int i = 0; i < CITY_COUNT; i++) tour_a[i] = CITY_W'(i);
        shuffle_cities(tour_a, CITY_COUNT);
        tour_b = tour_a;
        shuffle_cities(tour_b, len);
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            for (int i = 0; i < CITY_COUNT; i++) begin
                tour_a[i] = CITY_W'($urandom_range(0, CITY_COUNT - 1));
                tour_b[i] = CITY_W'($urandom_range(0, CITY_COUNT - 1));
            end
        end else if (kind >= 80) begin
            tour_b[$urandom_range(0, len - 1)] = CITY_W'($urandom_range(0, CITY_COUNT - 1));
        end
        for (int unsigned k = 0; k < count; k++) begin
            it.parent_one_city = tour_a[k];
            it.parent_two_city = tour_b[k];
            if (k == len - 1 && $urandom_range(0, 1) == 1) begin
                it.segment_end_a = CITY_W'($urandom_range(0, len - 1));
                it.segment_end_b = CITY_W'($urandom_range(0, len - 1));
            end else begin
                it.segment_end_a = CITY_W'($urandom_range(0, CITY_COUNT - 1));
                it.segment_end_b = CITY_W'($urandom_range(0, CITY_COUNT - 1));
            end
            drive_item(it);
        end
    endtask

    task automatic random_tours(input int unsigned item_target);
        int unsigned     first, len, part, pick;
        logic [TL_W-1:0] cfg_val;
        first = board.inputs_seen;
        while (board.inputs_seen - first < item_target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      cfg_val = TL_W'($urandom_range(2, 8));
            else if (pick < 82) cfg_val = TL_W'($urandom_range(9, 31));
            else if (pick < 90) cfg_val = TL_W'(32);
            else if (pick < 95) cfg_val = TL_W'($urandom_range(33, 63));
            else                cfg_val = TL_W'($urandom_range(0, 1));
            settle();
            write_tour_length(cfg_val);
            len = board.active_length();
            // partial load, then a shorter length so the load starts over
            if (len >= 4 && $urandom_range(0, 9) == 0) begin
                part = $urandom_range(2, len - 1);
                load_tour(len, part);
                settle();
                write_tour_length(TL_W'($urandom_range(2, part)));
                len = board.active_length();
            end
            load_tour(len, len);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        hold_left     = 0;
        cycle_count   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 70;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // shortest tours, ends at both extremes and beyond the tour
        write_tour_length(TL_W'(2));
        drive_fields(5'd0, 5'd31, 5'd0, 5'd31);
        drive_fields(5'd31, 5'd0, 5'd0, 5'd31);
        drive_fields(5'd31, 5'd0, 5'd31, 5'd0);
        drive_fields(5'd0, 5'd31, 5'd31, 5'd31);
        settle();
        // zero length saturates up to the minimum
        write_tour_length(TL_W'(0));
        drive_fields(5'd16, 5'd8, 5'd0, 5'd0);
        drive_fields(5'd8, 5'd16, 5'd0, 5'd0);
        settle();
        // parent one is not a permutation: child one runs out of source cities
        write_tour_length(TL_W'(3));
        drive_fields(5'd5, 5'd5, 5'd0, 5'd0);
        drive_fields(5'd5, 5'd7, 5'd0, 5'd0);
        drive_fields(5'd5, 5'd9, 5'd0, 5'd0);
        settle();
        // partial load, then length shrinks below the load count
        write_tour_length(TL_W'(5));
        drive_fields(5'd1, 5'd2, 5'd4, 5'd1);
        drive_fields(5'd2, 5'd1, 5'd3, 5'd2);
        drive_fields(5'd3, 5'd3, 5'd2, 5'd3);
        settle();
        write_tour_length(TL_W'(1));
        drive_fields(5'd30, 5'd29, 5'd2, 5'd3);
        drive_fields(5'd29, 5'd30, 5'd2, 5'd3);
        settle();
        // all-ones length saturates to the longest tour
        write_tour_length(TL_W'(63));
        load_tour(LEN_CAP, LEN_CAP);

        random_tours(90);

        send_idle_pct = 70;
        recv_idle_pct = 22;
        random_tours(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        write_tour_length(TL_W'(32));
        // receiver holds off while two full tours are offered back to back
        hold_left = HOLD_CYCLES;
        load_tour(LEN_CAP, LEN_CAP);
        load_tour(LEN_CAP, LEN_CAP);
        random_tours(20);

        settle();
        $display("Checked %0d results from %0d tours over %0d input transactions",
                 board.results_seen, board.tours_done, board.inputs_seen);
        $display("Lengths 2 to %0d, clamped ends, broken parents, three idle mixes, long stall",
                 LEN_CAP);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS permutation_segment_crossover");
        end else begin
            $display("FAIL permutation_segment_crossover");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/pcx_pkg.sv
design/pcx_ctrl.sv
design/pcx_datapath.sv
design/permutation_segment_crossover.sv
dv/permutation_segment_crossover_tb.sv
